/* hdl/bc1_pkg.sv */
package bc1_pkg;

    localparam int PIXELS   = 16;
    localparam int CNT_W    = $clog2(PIXELS);
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [7:0] FULL_SCALE = 8'd255;
    localparam logic [7:0] CLEAR      = 8'd0;

    // index code of the transparent entry in three-colour mode
    localparam logic [1:0] IDX_TRANSP = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_rgba;

    typedef struct packed {
        t_rgba [3:0] palette;
        logic [31:0] indices;
    } t_block;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } t_q_status;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    // x / 3 for x below 768 (so the result fits eight bits), by reciprocal 683 / 2048
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'd683;
        return p[18:11];
    endfunction

endpackage

/* hdl/bc1_front.sv */
module bc1_front (
    input  logic               i_valid,
    input  logic [63:0]        i_data,    // first_endpoint, second_endpoint, pixel_indices
    input  bc1_pkg::t_q_status i_q_status,
    output logic               o_ready,
    output logic               o_push,
    output bc1_pkg::t_block    o_block
);
    import bc1_pkg::*;

    logic [15:0] e0;
    logic [15:0] e1;
    logic        four;
    logic [7:0]  a [3];
    logic [7:0]  b [3];
    logic [7:0]  c2 [3];
    logic [7:0]  c3 [3];

    assign e0   = i_data[15:0];
    assign e1   = i_data[31:16];
    assign four = e0 > e1;

    assign a[0] = widen5(e0[15:11]);
    assign a[1] = widen6(e0[10:5]);
    assign a[2] = widen5(e0[4:0]);
    assign b[0] = widen5(e1[15:11]);
    assign b[1] = widen6(e1[10:5]);
    assign b[2] = widen5(e1[4:0]);

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            if (four) begin
                c2[ch] = div3({1'b0, a[ch], 1'b0} + 10'(b[ch]));
                c3[ch] = div3(10'(a[ch]) + {1'b0, b[ch], 1'b0});
            end else begin
                c2[ch] = 8'((9'(a[ch]) + 9'(b[ch])) >> 1);
                c3[ch] = FULL_SCALE;
            end
        end
    end

    always_comb begin
        o_block.indices = i_data[63:32];
        o_block.palette[0] = '{red: a[0], green: a[1], blue: a[2], alpha: FULL_SCALE};
        o_block.palette[1] = '{red: b[0], green: b[1], blue: b[2], alpha: FULL_SCALE};
        o_block.palette[2] = '{red: c2[0], green: c2[1], blue: c2[2], alpha: FULL_SCALE};
        o_block.palette[IDX_TRANSP] = '{red: c3[0], green: c3[1], blue: c3[2],
                                        alpha: four ? FULL_SCALE : CLEAR};
    end

    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

endmodule

/* hdl/bc1_queue.sv */
module bc1_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bc1_pkg::t_block    i_block,
    input  logic               i_pop,
    output bc1_pkg::t_block    o_head,
    output bc1_pkg::t_q_status o_status
);
    import bc1_pkg::*;

    t_block              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QCNT_W-1:0]   n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_block;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.count = r_count;
    assign o_status.full  = r_count == QCNT_W'(QDEPTH);
    assign o_status.empty = r_count == '0;

endmodule

/* hdl/bc1_back.sv */
module bc1_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bc1_pkg::t_block    i_head,
    input  bc1_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [39:0]        o_data,    // red, green, blue, alpha, pixel_x, pixel_y, zero pad
    output logic               o_last
);
    import bc1_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic             r_valid;
    t_rgba            r_pix;
    logic [1:0]       r_x;
    logic [1:0]       r_y;
    logic             r_last;
    logic             advance;
    logic             take;
    logic [1:0]       sel;

    assign advance = !r_valid || i_ready;
    assign take    = advance && !i_q_status.empty;
    assign sel     = i_head.indices[{r_cnt, 1'b0} +: 2];
    assign o_pop   = take && (r_cnt == CNT_W'(PIXELS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= take;
            if (take) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pix  <= i_head.palette[sel];
            r_x    <= r_cnt[1:0];
            r_y    <= r_cnt[3:2];
            r_last <= r_cnt == CNT_W'(PIXELS - 1);
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {4'b0, r_y, r_x, r_pix.alpha, r_pix.blue, r_pix.green, r_pix.red};
    assign o_last  = r_last;

endmodule

/* hdl/bc1_block_decoder_core.sv */
// channel  dir  tdata fields, low bit up                                           tlast
// s_axis   in   first_endpoint[15:0] second_endpoint[31:16] pixel_indices[63:32]  -
// m_axis   out  red green blue alpha (8 each) pixel_x pixel_y (2 each) pad[39:36] last_pixel
//
// one block in gives sixteen pixels out, one a cycle while i_m_tready is not held low;
// the pixel counter in the back end sets that number; with the back end idle, an accepted
// block is registered in the queue, then its first pixel in the output register behind
// o_m_tvalid; a two-block queue parts the front from the back, so input is taken while
// pixels drain; reset clears the queue pointers, pixel counter and output valid
module bc1_block_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // first_endpoint, second_endpoint, pixel_indices
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // red, green, blue, alpha, pixel_x, pixel_y, zero pad
    output logic        o_m_tlast
);
    import bc1_pkg::*;

    t_block    push_block;
    t_block    head;
    t_q_status q_status;
    logic      push;
    logic      pop;

    bc1_front u_front (
        .i_valid    (i_s_tvalid),
        .i_data     (i_s_tdata),
        .i_q_status (q_status),
        .o_ready    (o_s_tready),
        .o_push     (push),
        .o_block    (push_block)
    );

    bc1_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_block  (push_block),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    bc1_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_data     (o_m_tdata),
        .o_last     (o_m_tlast)
    );

`ifndef SYNTH
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata[33:32] == 2'd3 && o_m_tdata[35:34] == 2'd3)
        else $error("last pixel request not at the block corner");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= QCNT_W'(QDEPTH))
        else $error("block queue overfilled");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("block queue popped while empty");

    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> q_status.count != '0)
        else $error("accepted block missing from queue");
`endif

endmodule

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bc1_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;
    localparam int PIXEL_COUNT  = 16;

    localparam logic [7:0] OPAQUE      = 8'd255;
    localparam logic [7:0] TRANSPARENT = 8'd0;

    typedef struct packed {
        t_rgba      colour;
        logic [1:0] col;
        logic [1:0] row;
        logic       last;
    } t_pixel;

    typedef struct {
        logic [15:0] first_ep;
        logic [15:0] second_ep;
        logic [31:0] indices;
        bit          fixed;
        t_rgba       colour;
    } t_block_row;

    localparam int N_DIRECTED = 19;

    // rows marked fixed decode to one colour everywhere, the rest go through the decoder model
    t_block_row directed_rows [N_DIRECTED] = '{
        '{16'hFFFF, 16'h0000, 32'h0000_0000, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
        '{16'hFFFF, 16'h0000, 32'h5555_5555, 1'b1, '{8'd0,   8'd0,   8'd0,   8'd255}},
        '{16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd0}},
        '{16'h0000, 16'h0000, 32'h0000_0000, 1'b1, '{8'd0,   8'd0,   8'd0,   8'd255}},
        '{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd0}},
        '{16'h0000, 16'hFFFF, 32'hAAAA_AAAA, 1'b1, '{8'd127, 8'd127, 8'd127, 8'd255}},
        '{16'hFFFF, 16'h0000, 32'hE4E4_E4E4, 1'b0, '0},
        '{16'h0000, 16'hFFFF, 32'hE4E4_E4E4, 1'b0, '0},
        '{16'hF800, 16'h07E0, 32'h1B1B_1B1B, 1'b0, '0},
        '{16'h07E0, 16'h001F, 32'hD8D8_D8D8, 1'b0, '0},
        '{16'h001F, 16'hF800, 32'hE4E4_E4E4, 1'b0, '0},
        // top bit set on one side only: the compare must be unsigned
        '{16'h8000, 16'h7FFF, 32'hE4E4_E4E4, 1'b0, '0},
        '{16'h7FFF, 16'h8000, 32'hE4E4_E4E4, 1'b0, '0},
        '{16'hFFFF, 16'hFFFE, 32'hE4E4_E4E4, 1'b0, '0},
        '{16'h0001, 16'h0000, 32'hE4E4_E4E4, 1'b0, '0},
        '{16'h1234, 16'h1234, 32'hE4E4_E4E4, 1'b0, '0},
        '{16'hA5A5, 16'h5A5A, 32'h0F0F_0F0F, 1'b0, '0},
        '{16'h5A5A, 16'hA5A5, 32'hF0F0_F0F0, 1'b0, '0},
        '{16'h8410, 16'h8410, 32'hC3C3_C3C3, 1'b0, '0}
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata  = '0;   // first_endpoint, second_endpoint, pixel_indices
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;         // red, green, blue, alpha, pixel_x, pixel_y, zero pad
    logic        o_m_tlast;

    t_pixel pending_pixels [$];

    int gap_pct;
    int stall_pct;
    int hold_trigger;
    int hold_taken;
    int hold_left;
    int cycle_count;
    int mismatches;
    int blocks_sent;
    int pixels_checked;
    int four_colour_blocks;
    int three_colour_blocks;

    bc1_block_decoder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [7:0] expand_channel(input int value, input int bits);
        int wide;
        wide = (value << (8 - bits)) | (value >> (2 * bits - 8));
        return wide[7:0];
    endfunction

    function automatic t_rgba unpack565(input logic [15:0] c);
        t_rgba px;
        px.red   = expand_channel(int'(c[15:11]), 5);
        px.green = expand_channel(int'(c[10:5]), 6);
        px.blue  = expand_channel(int'(c[4:0]), 5);
        px.alpha = OPAQUE;
        return px;
    endfunction

    function automatic t_rgba [3:0] build_palette(input logic [15:0] first_ep,
                                                  input logic [15:0] second_ep);
        t_rgba [3:0] pal;
        t_rgba       a;
        t_rgba       b;
        a = unpack565(first_ep);
        b = unpack565(second_ep);
        pal[0] = a;
        pal[1] = b;
        if (first_ep > second_ep) begin
            pal[2].red   = 8'((2 * int'(a.red)   + int'(b.red))   / 3);
            pal[2].green = 8'((2 * int'(a.green) + int'(b.green)) / 3);
            pal[2].blue  = 8'((2 * int'(a.blue)  + int'(b.blue))  / 3);
            pal[2].alpha = OPAQUE;
            pal[3].red   = 8'((int'(a.red)   + 2 * int'(b.red))   / 3);
            pal[3].green = 8'((int'(a.green) + 2 * int'(b.green)) / 3);
            pal[3].blue  = 8'((int'(a.blue)  + 2 * int'(b.blue))  / 3);
            pal[3].alpha = OPAQUE;
        end else begin
            pal[2].red   = 8'((int'(a.red)   + int'(b.red))   / 2);
            pal[2].green = 8'((int'(a.green) + int'(b.green)) / 2);
            pal[2].blue  = 8'((int'(a.blue)  + int'(b.blue))  / 2);
            pal[2].alpha = OPAQUE;
            // transparent white
            pal[3] = '{8'd255, 8'd255, 8'd255, TRANSPARENT};
        end
        return pal;
    endfunction

    function automatic void queue_pixels(input t_rgba [3:0] pal, input logic [31:0] indices);
        t_pixel px;
        for (int k = 0; k < PIXEL_COUNT; k++) begin
            px.colour = pal[indices[2*k +: 2]];
            px.col    = 2'(k % 4);
            px.row    = 2'(k / 4);
            px.last   = (k == PIXEL_COUNT - 1);
            pending_pixels.push_back(px);
        end
    endfunction

    function automatic void note_failure(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endfunction

    function automatic void check_pixel(input logic [39:0] data, input logic last);
        t_pixel want;
        if (pending_pixels.size() == 0) begin
            note_failure($sformatf("unexpected pixel: tdata %h tlast %b", data, last));
            return;
        end
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (data[7:0] !== want.colour.red || data[15:8] !== want.colour.green ||
            data[23:16] !== want.colour.blue || data[31:24] !== want.colour.alpha ||
            data[33:32] !== want.col || data[35:34] !== want.row ||
            data[39:36] !== 4'b0 || last !== want.last) begin
            note_failure($sformatf(
                "px (%0d,%0d) want %h%h%h%h last %b got %h%h%h%h at (%0d,%0d) pad %h last %b",
                want.col, want.row, want.colour.red, want.colour.green, want.colour.blue,
                want.colour.alpha, want.last, data[7:0], data[15:8], data[23:16],
                data[31:24], data[33:32], data[35:34], data[39:36], last));
        end
    endfunction

    // result side: check on every transfer, then decide tready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_trigger != hold_taken) begin
                hold_taken = hold_trigger;
                hold_left  = HOLD_CYCLES;
            end
            if (o_m_tvalid && i_m_tready)
                check_pixel(o_m_tdata, o_m_tlast);
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels still outstanding",
                     cycle_count, pending_pixels.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic offer_block(input logic [15:0] first_ep, input logic [15:0] second_ep,
                               input logic [31:0] indices, input bit fixed,
                               input t_rgba colour);
        t_rgba [3:0] pal;
        while ($urandom_range(99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {indices, second_ep, first_ep};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        pal = fixed ? {colour, colour, colour, colour} : build_palette(first_ep, second_ep);
        queue_pixels(pal, indices);
        blocks_sent++;
        if (first_ep > second_ep)
            four_colour_blocks++;
        else
            three_colour_blocks++;
    endtask

    task automatic offer_random_blocks(input int count);
        logic [15:0] first_ep;
        logic [15:0] second_ep;
        logic [31:0] indices;
        int          flavour;
        for (int n = 0; n < count; n++) begin
            flavour   = $urandom_range(9);
            first_ep  = 16'($urandom_range(16'hFFFF));
            second_ep = 16'($urandom_range(16'hFFFF));
            indices   = $urandom;
            // equal and near-equal endpoints sit on the mode boundary
            if (flavour < 2)
                second_ep = first_ep;
            else if (flavour == 2)
                second_ep = first_ep + 16'($urandom_range(1)) - 16'($urandom_range(1));
            if ($urandom_range(19) == 0)
                indices = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            offer_block(first_ep, second_ep, indices, 1'b0, '0);
        end
    endtask

    initial begin
        gap_pct   = 0;
        stall_pct = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            offer_block(directed_rows[r].first_ep, directed_rows[r].second_ep,
                        directed_rows[r].indices, directed_rows[r].fixed,
                        directed_rows[r].colour);
        offer_random_blocks(40);

        gap_pct   = 79;
        stall_pct = 0;
        offer_random_blocks(30);

        gap_pct   = 0;
        stall_pct = 79;
        offer_random_blocks(30);

        gap_pct   = 37;
        stall_pct = 37;
        offer_random_blocks(30);

        // long receiver hold with the sender flat out, so the queue fills and tready drops
        gap_pct   = 0;
        stall_pct = 0;
        hold_trigger++;
        offer_random_blocks(20);

        i_s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_pixels.size() != 0)
            note_failure($sformatf("%0d pixels never arrived", pending_pixels.size()));

        $display("decoded %0d blocks (%0d four-colour, %0d three-colour), %0d pixels compared",
                 blocks_sent, four_colour_blocks, three_colour_blocks, pixels_checked);
        $display("idle and stall mixes plus one %0d-cycle output hold; %0d errors",
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
hdl/bc1_pkg.sv
hdl/bc1_front.sv
hdl/bc1_queue.sv
hdl/bc1_back.sv
hdl/bc1_block_decoder_core.sv
tb/tb_top.sv
